/* sv/fep_pkg.sv */
// Shared types, constants and palette lookup for the fire propagation block.
package fep_pkg;

  localparam int DEF_WIDTH  = 256;
  localparam int DEF_HEIGHT = 128;
  localparam int VAL_W      = 6;
  localparam int COLOR_W    = 24;

  localparam logic [VAL_W-1:0] FIRE_MAX  = 6'd36;
  localparam logic [VAL_W-1:0] FIRE_ZERO = 6'd0;

  localparam logic signed [2:0] WIND_RESET  = 3'sd1;
  localparam logic signed [2:0] WIND_UNUSED = -3'sd4;
  localparam logic signed [2:0] WIND_MIN    = -3'sd3;
  localparam logic signed [2:0] WIND_NONE   = 3'sd0;

  typedef enum logic [1:0] {
    OP_PROPAGATE,
    OP_IGNITE,
    OP_EXTINGUISH,
    OP_READ
  } fep_op_t;

  // Per-word control carried from decode into the read/modify/write stage
  typedef struct packed {
    fep_op_t op;
    logic    ignored;  // propagate with no row below
    logic    zero_rd;  // addressed row lies outside the frame
    logic    decay;    // decrement copied intensity
  } fep_ctl_t;

  function automatic logic [COLOR_W-1:0] palette(input logic [VAL_W-1:0] v);
    logic [COLOR_W-1:0] c;
    case (v)
      6'd0:    c = 24'h070707;
      6'd1:    c = 24'h1F0707;
      6'd2:    c = 24'h2F0F07;
      6'd3:    c = 24'h470F07;
      6'd4:    c = 24'h571707;
      6'd5:    c = 24'h671F07;
      6'd6:    c = 24'h771F07;
      6'd7:    c = 24'h8F2707;
      6'd8:    c = 24'h9F2F07;
      6'd9:    c = 24'hAF3F07;
      6'd10:   c = 24'hBF4707;
      6'd11:   c = 24'hC74707;
      6'd12:   c = 24'hDF4F07;
      6'd13:   c = 24'hDF5707;
      6'd14:   c = 24'hDF5707;
      6'd15:   c = 24'hD75F07;
      6'd16:   c = 24'hD75F07;
      6'd17:   c = 24'hD7670F;
      6'd18:   c = 24'hCF6F0F;
      6'd19:   c = 24'hCF770F;
      6'd20:   c = 24'hCF7F0F;
      6'd21:   c = 24'hCF8717;
      6'd22:   c = 24'hC78717;
      6'd23:   c = 24'hC78F17;
      6'd24:   c = 24'hC7971F;
      6'd25:   c = 24'hBF9F1F;
      6'd26:   c = 24'hBF9F1F;
      6'd27:   c = 24'hBFA727;
      6'd28:   c = 24'hBFA727;
      6'd29:   c = 24'hBFAF2F;
      6'd30:   c = 24'hB7AF2F;
      6'd31:   c = 24'hB7B72F;
      6'd32:   c = 24'hB7B737;
      6'd33:   c = 24'hCFCF6F;
      6'd34:   c = 24'hDFDF9F;
      6'd35:   c = 24'hEFEFC7;
      default: c = 24'hFFFFFF;
    endcase
    return c;
  endfunction

endpackage

/* sv/fep_frame_mem.sv */
// Frame store: one write port, one read port, registered read data.
module fep_frame_mem #(
  parameter int DEPTH = fep_pkg::DEF_WIDTH * fep_pkg::DEF_HEIGHT
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(DEPTH)-1:0]   waddr,
  input  logic [fep_pkg::VAL_W-1:0]  wdata,
  input  logic                       re,
  input  logic [$clog2(DEPTH)-1:0]   raddr,
  output logic [fep_pkg::VAL_W-1:0]  q
);

  logic [fep_pkg::VAL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read-before-write on a same-address collision
  always_ff @(posedge clk) begin
    if (re) begin
      q <= mem[raddr];
    end
  end

endmodule

/* sv/fep_clear.sv */
// Post-reset sweep that zeroes every frame entry, one per cycle.
module fep_clear #(
  parameter int DEPTH = fep_pkg::DEF_WIDTH * fep_pkg::DEF_HEIGHT
) (
  input  logic                     clk,
  input  logic                     rst,
  output logic                     busy,
  output logic [$clog2(DEPTH)-1:0] addr
);

  localparam int AW = $clog2(DEPTH);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
      addr <= '0;
    end else if (busy) begin
      addr <= addr + AW'(1);
      if (addr == LAST) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

/* sv/fep_decode.sv */
// Word decode: column wrap, target column and frame addresses.
module fep_decode #(
  parameter int WIDTH  = fep_pkg::DEF_WIDTH,
  parameter int HEIGHT = fep_pkg::DEF_HEIGHT
) (
  input  logic [1:0]                         opcode,
  input  logic [7:0]                         column,
  input  logic [6:0]                         row,
  input  logic [1:0]                         decay_roll,
  input  logic [1:0]                         spread_roll,
  input  logic                               wind_coin,
  input  logic signed [2:0]                  wind,
  output fep_pkg::fep_ctl_t                  ctl,
  output logic [$clog2(WIDTH*HEIGHT)-1:0]    raddr,
  output logic [$clog2(WIDTH*HEIGHT)-1:0]    waddr,
  output logic [$clog2(WIDTH)-1:0]           col_out
);

  localparam int CW = $clog2(WIDTH);
  localparam int RW = $clog2(HEIGHT);
  localparam int AW = $clog2(WIDTH * HEIGHT);
  localparam int TW = CW + 2;
  localparam logic [AW-1:0] BOTTOM = AW'((HEIGHT - 1) * WIDTH);

  // column modulo WIDTH as a constant table
  logic [CW-1:0] col_tab [256];
  for (genvar g = 0; g < 256; g++) begin : g_col
    assign col_tab[g] = CW'(g % WIDTH);
  end

  fep_pkg::fep_op_t        op;
  logic [CW-1:0]           col_m;
  logic signed [2:0]       spr_off;
  logic signed [2:0]       wind_off;
  logic signed [TW-1:0]    t;
  logic [CW-1:0]           tw;
  logic [RW-1:0]           row_r;
  logic [AW-1:0]           base;
  logic                    ignored;
  logic                    zero_rd;

  always_comb begin
    op      = fep_pkg::fep_op_t'(opcode);
    col_m   = col_tab[column];
    ignored = (int'(row) + 1) >= HEIGHT;
    zero_rd = int'(row) >= HEIGHT;

    case (spread_roll)
      2'd0:    spr_off = -3'sd1;
      2'd1:    spr_off = 3'sd0;
      default: spr_off = 3'sd1;
    endcase
    wind_off = wind_coin ? wind : fep_pkg::WIND_NONE;

    // range is -4 .. WIDTH+3, one correction wraps it
    t = $signed({2'b00, col_m}) + TW'(spr_off) + TW'(wind_off);
    if (t < 0) begin
      tw = CW'(t + TW'(WIDTH));
    end else if (t >= TW'(WIDTH)) begin
      tw = CW'(t - TW'(WIDTH));
    end else begin
      tw = CW'(t);
    end

    row_r = RW'(row);
    base  = AW'(row_r) * AW'(WIDTH);

    raddr = base + AW'(col_m);
    if (op == fep_pkg::OP_PROPAGATE && !ignored) begin
      raddr = base + AW'(WIDTH) + AW'(col_m);
    end

    if (op == fep_pkg::OP_PROPAGATE) begin
      waddr = base + AW'(tw);
    end else begin
      waddr = BOTTOM + AW'(col_m);
    end

    col_out = (op == fep_pkg::OP_PROPAGATE && !ignored) ? tw : col_m;

    ctl.op      = op;
    ctl.ignored = ignored;
    ctl.zero_rd = zero_rd;
    ctl.decay   = decay_roll[1];
  end

endmodule

/* sv/fire_effect_propagation_top.sv */
// Fire propagation block: frame store read/modify/write pipeline.
// An accepted input word passes stage 1 and then the output register, where its result is valid.
// Throughput: one word per cycle unless out_stall holds it; the frame store has one read
//   and one write port, and a read that meets the write of the word ahead is forwarded.
// Reset (rst, synchronous): wind returns to 1, pipeline empties, and a clearing
//   pass over all WIDTH*HEIGHT entries (32768 by default) zeroes the frame; in_stall
//   is high throughout, configuration writes are still taken.
module fire_effect_propagation_top #(
  parameter int WIDTH  = fep_pkg::DEF_WIDTH,
  parameter int HEIGHT = fep_pkg::DEF_HEIGHT
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration
  input  logic                          cfg_we,
  input  logic signed [2:0]             cfg_wdata,
  // input word
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    opcode,
  input  logic [7:0]                    column,
  input  logic [6:0]                    row,
  input  logic [1:0]                    decay_roll,
  input  logic [1:0]                    spread_roll,
  input  logic                          wind_coin,
  // result word
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [5:0]                    pixel_value,
  output logic [23:0]                   pixel_color,
  output logic [7:0]                    target_column,
  output logic                          status
);

  localparam int DEPTH = WIDTH * HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(WIDTH);
  localparam int VW    = fep_pkg::VAL_W;

  // wind speed register; the unused pattern -4 is stored as -3
  logic signed [2:0] wind;

  always_ff @(posedge clk) begin
    if (rst) begin
      wind <= fep_pkg::WIND_RESET;
    end else if (cfg_we) begin
      wind <= (cfg_wdata == fep_pkg::WIND_UNUSED) ? fep_pkg::WIND_MIN : cfg_wdata;
    end
  end

  // decode of the word on the input port
  fep_pkg::fep_ctl_t dec_ctl;
  logic [AW-1:0]     dec_raddr;
  logic [AW-1:0]     dec_waddr;
  logic [CW-1:0]     dec_col;

  fep_decode #(
    .WIDTH  (WIDTH),
    .HEIGHT (HEIGHT)
  ) u_decode (
    .opcode      (opcode),
    .column      (column),
    .row         (row),
    .decay_roll  (decay_roll),
    .spread_roll (spread_roll),
    .wind_coin   (wind_coin),
    .wind        (wind),
    .ctl         (dec_ctl),
    .raddr       (dec_raddr),
    .waddr       (dec_waddr),
    .col_out     (dec_col)
  );

  // clearing pass after reset
  logic          clr_busy;
  logic [AW-1:0] clr_addr;

  fep_clear #(
    .DEPTH (DEPTH)
  ) u_clear (
    .clk  (clk),
    .rst  (rst),
    .busy (clr_busy),
    .addr (clr_addr)
  );

  // handshake
  logic s1_valid;
  logic s1_advance;
  logic in_accept;

  assign s1_advance = s1_valid && (!out_valid || !out_stall);
  assign in_stall   = clr_busy || (s1_valid && !s1_advance);
  assign in_accept  = in_valid && !in_stall;

  // stage 1: word waits here while its read is in flight
  fep_pkg::fep_ctl_t s1_ctl;
  logic [AW-1:0]     s1_waddr;
  logic [CW-1:0]     s1_col;
  logic              fwd_hit;
  logic [VW-1:0]     fwd_data;

  // read/modify/write
  logic [VW-1:0] mem_q;
  logic [VW-1:0] rd;
  logic [VW-1:0] s2_val;
  logic          s2_wr;
  logic          s2_we_now;

  always_comb begin
    rd     = fwd_hit ? fwd_data : mem_q;
    s2_val = rd;
    s2_wr  = 1'b0;
    unique case (s1_ctl.op)
      fep_pkg::OP_PROPAGATE: begin
        if (s1_ctl.ignored) begin
          s2_val = s1_ctl.zero_rd ? fep_pkg::FIRE_ZERO : rd;
        end else begin
          s2_val = (s1_ctl.decay && rd != fep_pkg::FIRE_ZERO) ? rd - VW'(1) : rd;
          s2_wr  = 1'b1;
        end
      end
      fep_pkg::OP_IGNITE: begin
        s2_val = fep_pkg::FIRE_MAX;
        s2_wr  = 1'b1;
      end
      fep_pkg::OP_EXTINGUISH: begin
        s2_val = fep_pkg::FIRE_ZERO;
        s2_wr  = 1'b1;
      end
      fep_pkg::OP_READ: begin
        s2_val = s1_ctl.zero_rd ? fep_pkg::FIRE_ZERO : rd;
      end
      default: begin
        s2_val = rd;
      end
    endcase
  end

  assign s2_we_now = s1_advance && s2_wr;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  // new read issued in the same edge as the older word's write sees stale data
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_ctl   <= dec_ctl;
      s1_waddr <= dec_waddr;
      s1_col   <= dec_col;
      fwd_hit  <= s2_we_now && (dec_raddr == s1_waddr);
      fwd_data <= s2_val;
    end
  end

  fep_frame_mem #(
    .DEPTH (DEPTH)
  ) u_mem (
    .clk   (clk),
    .we    (clr_busy || s2_we_now),
    .waddr (clr_busy ? clr_addr : s1_waddr),
    .wdata (clr_busy ? fep_pkg::FIRE_ZERO : s2_val),
    .re    (in_accept),
    .raddr (dec_raddr),
    .q     (mem_q)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      pixel_value   <= s2_val;
      pixel_color   <= fep_pkg::palette(s2_val);
      target_column <= 8'(s1_col);
      status        <= (s1_ctl.op == fep_pkg::OP_PROPAGATE) && s1_ctl.ignored;
    end
  end

  // no word enters during the clearing pass
  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    in_accept |-> !clr_busy)
    else $error("word accepted during clearing pass");

  // every word leaving stage 1 shows up at the output
  a_advance_out: assert property (@(posedge clk) disable iff (rst)
    s1_advance |=> out_valid)
    else $error("stage 1 word lost");

  // item writes never collide with the clearing sweep
  a_wr_not_clear: assert property (@(posedge clk) disable iff (rst)
    s2_we_now |-> !clr_busy)
    else $error("frame write during clearing pass");

  // intensities stay in range
  a_val_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pixel_value <= fep_pkg::FIRE_MAX)
    else $error("pixel value out of range");

endmodule
